// ----- hw/rtl/dchs_pkg.sv -----
// Shared types, constants and helpers for the DHCP client handshake unit.
// Used by every module of the block; depends on nothing.
package dchs_pkg;

  // Reply packet geometry
  localparam int unsigned MAX_PACKET_BYTES = 552;
  localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);
  localparam logic [POS_W-1:0] POS_OP = POS_W'(0);
  localparam logic [POS_W-1:0] POS_XID_FIRST = POS_W'(4);
  localparam logic [POS_W-1:0] POS_XID_LAST = POS_W'(7);
  localparam logic [POS_W-1:0] POS_YI_FIRST = POS_W'(16);
  localparam logic [POS_W-1:0] POS_YI_LAST = POS_W'(19);
  localparam logic [POS_W-1:0] POS_MAGIC_FIRST = POS_W'(236);
  localparam logic [POS_W-1:0] POS_MAGIC_LAST = POS_W'(239);
  localparam logic [POS_W-1:0] POS_OPTIONS = POS_W'(240);

  // Protocol constants
  localparam logic [31:0] DHCP_MAGIC = 32'h6382_5363;
  localparam logic [7:0] TAG_END = 8'd255;
  localparam logic [7:0] TAG_TYPE = 8'd53;
  localparam logic [7:0] TAG_SERVER = 8'd54;
  localparam logic [7:0] OP_REPLY = 8'd2;
  localparam logic [7:0] TYPE_OFFER = 8'd2;
  localparam logic [7:0] TYPE_ACK = 8'd5;
  localparam logic [7:0] TYPE_NAK = 8'd6;
  localparam logic [7:0] SERVER_ID_LEN = 8'd4;
  localparam logic [7:0] ATTEMPT_SAT = 8'd255;
  localparam logic [7:0] RETRIES_RESET = 8'd3;

  // Header check bits
  localparam int unsigned HDR_OP = 0;
  localparam int unsigned HDR_XID = 1;
  localparam int unsigned HDR_MAGIC = 2;

  // Item queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_BYTE    = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ACT_DISCOVER = 3'd0,
    ACT_REQUEST  = 3'd1,
    ACT_BOUND    = 3'd2,
    ACT_NAK      = 3'd3,
    ACT_NO_OFFER = 3'd4,
    ACT_NO_ACK   = 3'd5
  } action_e;

  // Classified operation handed to the back end
  typedef enum logic [2:0] {
    OP_START   = 3'b001,
    OP_BYTE    = 3'b010,
    OP_TIMEOUT = 3'b100
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_OFFER = 3'b010,
    PH_ACK   = 3'b100
  } phase_e;

  typedef enum logic [3:0] {
    WALK_TAG  = 4'b0001,
    WALK_LEN  = 4'b0010,
    WALK_VAL  = 4'b0100,
    WALK_STOP = 4'b1000
  } walk_e;

  typedef enum logic [2:0] {
    CAP_NONE    = 3'b001,
    CAP_PENDING = 3'b010,
    CAP_FOUND   = 3'b100
  } cap_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] xid;
  } q_entry_t;

  // Byte of a 32-bit word, first wire byte at index 0
  function automatic logic [7:0] byte_of(input logic [31:0] word, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = word[31:24];
      2'd1:    b = word[23:16];
      2'd2:    b = word[15:8];
      default: b = word[7:0];
    endcase
    return b;
  endfunction

endpackage

// ----- hw/rtl/dchs_front.sv -----
// Front end: accepts input items, classifies them and pushes them into the queue.
// Depends on dchs_pkg.
module dchs_front (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  input  logic [31:0]        start_xid_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output dchs_pkg::q_entry_t push_entry_o
);

  logic    keep;
  dchs_pkg::op_e op;

  // Decode kind; the unused code is accepted and dropped
  always_comb begin
    keep = 1'b1;
    op   = dchs_pkg::OP_START;
    case (dchs_pkg::kind_e'(kind_i))
      dchs_pkg::KIND_START:   op = dchs_pkg::OP_START;
      dchs_pkg::KIND_BYTE:    op = dchs_pkg::OP_BYTE;
      dchs_pkg::KIND_TIMEOUT: op = dchs_pkg::OP_TIMEOUT;
      default:                keep = 1'b0;
    endcase
  end

  // Dropped items need no queue slot
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i && keep;

  assign push_entry_o.op        = op;
  assign push_entry_o.data_byte = data_byte_i;
  assign push_entry_o.last_byte = last_byte_i;
  assign push_entry_o.xid       = start_xid_i;

endmodule

// ----- hw/rtl/dchs_queue.sv -----
// Short item queue that decouples the front end from the back end.
// Depends on dchs_pkg.
module dchs_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  dchs_pkg::q_entry_t push_entry_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output dchs_pkg::q_entry_t pop_entry_o
);

  dchs_pkg::q_entry_t mem_q [dchs_pkg::QUEUE_DEPTH];
  logic [dchs_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [dchs_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign push_ready_o = (cnt_q != dchs_pkg::QCNT_W'(dchs_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ----- hw/rtl/dchs_back.sv -----
// Back end: handshake state, on-the-fly reply parsing, judging and result register.
// Depends on dchs_pkg.
module dchs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  dchs_pkg::q_entry_t pop_entry_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         action_o,
  output logic [31:0]        address_o,
  output logic [31:0]        server_ident_o
);

  localparam int unsigned POS_W = dchs_pkg::POS_W;

  logic [7:0]        max_q;
  dchs_pkg::phase_e  phase_q, phase_d;
  logic [7:0]        att_q, att_d;
  logic [31:0]       xid_q, xid_d;
  logic [31:0]       offer_q, offer_d;
  logic [31:0]       sid_q, sid_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [2:0]        hdr_q, hdr_d;
  logic [31:0]       yi_q, yi_d;
  dchs_pkg::walk_e   walk_q, walk_d;
  logic [7:0]        tag_q, tag_d;
  logic [7:0]        rem_q, rem_d;
  dchs_pkg::cap_e    mt_st_q, mt_st_d;
  logic              mt_has_q, mt_has_d;
  logic [7:0]        mt_val_q, mt_val_d;
  dchs_pkg::cap_e    sv_st_q, sv_st_d;
  logic [7:0]        sv_len_q, sv_len_d;
  logic [31:0]       sv_val_q, sv_val_d;

  logic              go, clr, use_att, type_ok;
  logic              res_valid;
  dchs_pkg::action_e res_action;
  logic [31:0]       res_addr, res_sid;
  logic              out_valid_q;
  logic [2:0]        out_action_q;
  logic [31:0]       out_addr_q, out_sid_q;
  logic [7:0]        b;
  logic [7:0]        rem_dec;
  logic              out_free;

  // An item is taken whenever the result register can take its answer
  assign out_free    = !out_valid_q || out_ready_i;
  assign pop_ready_o = out_free;
  assign go          = pop_valid_i && out_free;
  assign b           = pop_entry_i.data_byte;
  assign rem_dec     = rem_q - 8'd1;

  // Next state for one item: absorb, judge, then apply retries and packet clear
  always_comb begin
    phase_d    = phase_q;
    att_d      = att_q;
    xid_d      = xid_q;
    offer_d    = offer_q;
    sid_d      = sid_q;
    pos_d      = pos_q;
    hdr_d      = hdr_q;
    yi_d       = yi_q;
    walk_d     = walk_q;
    tag_d      = tag_q;
    rem_d      = rem_q;
    mt_st_d    = mt_st_q;
    mt_has_d   = mt_has_q;
    mt_val_d   = mt_val_q;
    sv_st_d    = sv_st_q;
    sv_len_d   = sv_len_q;
    sv_val_d   = sv_val_q;
    clr        = 1'b0;
    use_att    = 1'b0;
    type_ok    = 1'b0;
    res_valid  = 1'b0;
    res_action = dchs_pkg::ACT_DISCOVER;
    res_addr   = '0;
    res_sid    = '0;

    if (go) begin
      case (pop_entry_i.op)
        dchs_pkg::OP_START: begin
          xid_d     = pop_entry_i.xid;
          att_d     = '0;
          offer_d   = '0;
          sid_d     = '0;
          clr       = 1'b1;
          res_valid = 1'b1;
          if (max_q == '0) begin
            phase_d    = dchs_pkg::PH_IDLE;
            res_action = dchs_pkg::ACT_NO_OFFER;
          end else begin
            phase_d    = dchs_pkg::PH_OFFER;
            res_action = dchs_pkg::ACT_DISCOVER;
          end
        end
        dchs_pkg::OP_BYTE: begin
          if (phase_q != dchs_pkg::PH_IDLE) begin
            // Absorb the byte; bytes past the maximum length are dropped
            if (pos_q < dchs_pkg::POS_MAX) begin
              pos_d = pos_q + 1'b1;
              if (pos_q == dchs_pkg::POS_OP && b != dchs_pkg::OP_REPLY) begin
                hdr_d[dchs_pkg::HDR_OP] = 1'b0;
              end
              if (pos_q >= dchs_pkg::POS_XID_FIRST && pos_q <= dchs_pkg::POS_XID_LAST &&
                  dchs_pkg::byte_of(xid_q, pos_q[1:0]) != b) begin
                hdr_d[dchs_pkg::HDR_XID] = 1'b0;
              end
              if (pos_q >= dchs_pkg::POS_YI_FIRST && pos_q <= dchs_pkg::POS_YI_LAST) begin
                yi_d = {yi_q[23:0], b};
              end
              if (pos_q >= dchs_pkg::POS_MAGIC_FIRST && pos_q <= dchs_pkg::POS_MAGIC_LAST &&
                  dchs_pkg::byte_of(dchs_pkg::DHCP_MAGIC, pos_q[1:0]) != b) begin
                hdr_d[dchs_pkg::HDR_MAGIC] = 1'b0;
              end
              // Option walk
              if (pos_q >= dchs_pkg::POS_OPTIONS) begin
                case (walk_q)
                  dchs_pkg::WALK_TAG: begin
                    if (b == dchs_pkg::TAG_END) begin
                      walk_d = dchs_pkg::WALK_STOP;
                    end else begin
                      tag_d  = b;
                      rem_d  = '0;
                      walk_d = dchs_pkg::WALK_LEN;
                    end
                  end
                  dchs_pkg::WALK_LEN: begin
                    if (tag_q == dchs_pkg::TAG_TYPE && mt_st_q == dchs_pkg::CAP_NONE) begin
                      mt_st_d  = (b == '0) ? dchs_pkg::CAP_FOUND : dchs_pkg::CAP_PENDING;
                      mt_has_d = 1'b0;
                      mt_val_d = '0;
                    end
                    if (tag_q == dchs_pkg::TAG_SERVER && sv_st_q == dchs_pkg::CAP_NONE) begin
                      sv_st_d  = (b == '0) ? dchs_pkg::CAP_FOUND : dchs_pkg::CAP_PENDING;
                      sv_len_d = b;
                      sv_val_d = '0;
                    end
                    rem_d  = b;
                    walk_d = (b == '0) ? dchs_pkg::WALK_TAG : dchs_pkg::WALK_VAL;
                  end
                  dchs_pkg::WALK_VAL: begin
                    if (mt_st_q == dchs_pkg::CAP_PENDING && !mt_has_q) begin
                      mt_has_d = 1'b1;
                      mt_val_d = b;
                    end
                    if (sv_st_q == dchs_pkg::CAP_PENDING) begin
                      sv_val_d = {sv_val_q[23:0], b};
                    end
                    rem_d = rem_dec;
                    if (rem_dec == '0) begin
                      if (mt_st_q == dchs_pkg::CAP_PENDING) begin
                        mt_st_d = dchs_pkg::CAP_FOUND;
                      end
                      if (sv_st_q == dchs_pkg::CAP_PENDING) begin
                        sv_st_d = dchs_pkg::CAP_FOUND;
                      end
                      walk_d = dchs_pkg::WALK_TAG;
                    end
                  end
                  default: ;
                endcase
              end
            end

            // Judge the reply at its last byte
            if (pop_entry_i.last_byte) begin
              type_ok = (mt_st_d == dchs_pkg::CAP_FOUND) && mt_has_d;
              if (pos_d < dchs_pkg::POS_OPTIONS) begin
                use_att = 1'b1;
              end else if (phase_q == dchs_pkg::PH_OFFER) begin
                if (hdr_d != 3'b111 || !type_ok || mt_val_d != dchs_pkg::TYPE_OFFER ||
                    yi_d == '0) begin
                  use_att = 1'b1;
                end else begin
                  offer_d = yi_d;
                  sid_d   = (sv_st_d == dchs_pkg::CAP_FOUND &&
                             sv_len_d == dchs_pkg::SERVER_ID_LEN) ? sv_val_d : '0;
                  clr       = 1'b1;
                  att_d     = '0;
                  res_valid = 1'b1;
                  if (max_q == '0) begin
                    phase_d    = dchs_pkg::PH_IDLE;
                    res_action = dchs_pkg::ACT_NO_ACK;
                  end else begin
                    phase_d    = dchs_pkg::PH_ACK;
                    res_action = dchs_pkg::ACT_REQUEST;
                    res_addr   = offer_d;
                    res_sid    = sid_d;
                  end
                end
              end else begin
                // Ack phase: cookie not checked
                if (hdr_d[dchs_pkg::HDR_XID:dchs_pkg::HDR_OP] != 2'b11 || !type_ok) begin
                  use_att = 1'b1;
                end else if (mt_val_d == dchs_pkg::TYPE_NAK) begin
                  clr        = 1'b1;
                  phase_d    = dchs_pkg::PH_IDLE;
                  res_valid  = 1'b1;
                  res_action = dchs_pkg::ACT_NAK;
                end else if (mt_val_d != dchs_pkg::TYPE_ACK || yi_d == '0) begin
                  use_att = 1'b1;
                end else begin
                  clr        = 1'b1;
                  phase_d    = dchs_pkg::PH_IDLE;
                  res_valid  = 1'b1;
                  res_action = dchs_pkg::ACT_BOUND;
                  res_addr   = yi_d;
                  res_sid    = sid_q;
                end
              end
            end
          end
        end
        dchs_pkg::OP_TIMEOUT: begin
          if (phase_q != dchs_pkg::PH_IDLE) begin
            use_att = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // One attempt used up: retry or give up
    if (use_att) begin
      clr       = 1'b1;
      att_d     = (att_q == dchs_pkg::ATTEMPT_SAT) ? att_q : att_q + 8'd1;
      res_valid = 1'b1;
      if (att_d >= max_q) begin
        phase_d    = dchs_pkg::PH_IDLE;
        res_action = (phase_q == dchs_pkg::PH_OFFER) ? dchs_pkg::ACT_NO_OFFER
                                                     : dchs_pkg::ACT_NO_ACK;
      end else if (phase_q == dchs_pkg::PH_OFFER) begin
        res_action = dchs_pkg::ACT_DISCOVER;
      end else begin
        res_action = dchs_pkg::ACT_REQUEST;
        res_addr   = offer_q;
        res_sid    = sid_q;
      end
    end

    // Drop any partial reply
    if (clr) begin
      pos_d    = '0;
      hdr_d    = 3'b111;
      yi_d     = '0;
      walk_d   = dchs_pkg::WALK_TAG;
      tag_d    = '0;
      rem_d    = '0;
      mt_st_d  = dchs_pkg::CAP_NONE;
      mt_has_d = 1'b0;
      mt_val_d = '0;
      sv_st_d  = dchs_pkg::CAP_NONE;
      sv_len_d = '0;
      sv_val_d = '0;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= dchs_pkg::RETRIES_RESET;
    end else if (cfg_valid_i) begin
      max_q <= cfg_data_i;
    end
  end

  // Handshake and parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= dchs_pkg::PH_IDLE;
      att_q    <= '0;
      xid_q    <= '0;
      offer_q  <= '0;
      sid_q    <= '0;
      pos_q    <= '0;
      hdr_q    <= 3'b111;
      yi_q     <= '0;
      walk_q   <= dchs_pkg::WALK_TAG;
      tag_q    <= '0;
      rem_q    <= '0;
      mt_st_q  <= dchs_pkg::CAP_NONE;
      mt_has_q <= 1'b0;
      mt_val_q <= '0;
      sv_st_q  <= dchs_pkg::CAP_NONE;
      sv_len_q <= '0;
      sv_val_q <= '0;
    end else begin
      phase_q  <= phase_d;
      att_q    <= att_d;
      xid_q    <= xid_d;
      offer_q  <= offer_d;
      sid_q    <= sid_d;
      pos_q    <= pos_d;
      hdr_q    <= hdr_d;
      yi_q     <= yi_d;
      walk_q   <= walk_d;
      tag_q    <= tag_d;
      rem_q    <= rem_d;
      mt_st_q  <= mt_st_d;
      mt_has_q <= mt_has_d;
      mt_val_q <= mt_val_d;
      sv_st_q  <= sv_st_d;
      sv_len_q <= sv_len_d;
      sv_val_q <= sv_val_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= go && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && go && res_valid) begin
      out_action_q <= res_action;
      out_addr_q   <= res_addr;
      out_sid_q    <= res_sid;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign action_o       = out_action_q;
  assign address_o      = out_addr_q;
  assign server_ident_o = out_sid_q;

endmodule

// ----- hw/rtl/dhcp_client_handshake_unit.sv -----
// DHCP client handshake unit, top level: front end, item queue and back end.
// Depends on dchs_pkg, dchs_front, dchs_queue and dchs_back.
//
// Runs the DISCOVER/OFFER then REQUEST/ACK exchange of a DHCP client. A start
// item sets the transaction id and answers "send discover" ("no offer" if the
// retry limit is zero); reply bytes then stream in one item per byte, and the
// item with the last byte gives the verdict (send discover or request, bound,
// NAK failure, no offer, no ack). Timeouts outside the idle phase use up one
// attempt and answer with a resend or a give-up. Items go into a four-entry
// queue; the back end takes one item per clock and updates the whole header
// check and option walk in that cycle, so the sustained rate is one item per
// clock while results are taken. A result is registered as its item is taken
// by the back end, and the output register holds it while the consumer stalls.
// The retry limit register is written through the cfg channel, which is always
// ready; write it only while no item is in flight.
module dhcp_client_handshake_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [31:0] start_xid_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  action_o,
  output logic [31:0] address_o,
  output logic [31:0] server_ident_o
);

  logic               push_valid, push_ready;
  dchs_pkg::q_entry_t push_entry;
  logic               pop_valid, pop_ready;
  dchs_pkg::q_entry_t pop_entry;

  assign cfg_ready_o = 1'b1;

  dchs_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .start_xid_i  (start_xid_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  dchs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  dchs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_entry_i    (pop_entry),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .action_o       (action_o),
    .address_o      (address_o),
    .server_ident_o (server_ident_o)
  );

endmodule

// ----- hw/rtl/dchs_checker.sv -----
// Port-level checks for the DHCP client handshake unit, bound to the top level.
// Depends on dchs_pkg and dhcp_client_handshake_unit.
module dchs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  action_o,
  input logic [31:0] address_o,
  input logic [31:0] server_ident_o
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(action_o) && $stable(address_o) && $stable(server_ident_o))
    else $error("result changed while stalled");

  // Only defined action codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> action_o <= dchs_pkg::ACT_NO_ACK)
    else $error("undefined action code");

  // Actions without an address carry zeros
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == dchs_pkg::ACT_DISCOVER || action_o == dchs_pkg::ACT_NAK ||
                    action_o == dchs_pkg::ACT_NO_OFFER || action_o == dchs_pkg::ACT_NO_ACK)
      |-> address_o == '0 && server_ident_o == '0)
    else $error("address fields set on an address-free action");

  // Request and bound always carry a nonzero address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == dchs_pkg::ACT_REQUEST || action_o == dchs_pkg::ACT_BOUND)
      |-> address_o != '0)
    else $error("request or bound without an address");

endmodule

bind dhcp_client_handshake_unit dchs_checker u_dchs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .action_o       (action_o),
  .address_o      (address_o),
  .server_ident_o (server_ident_o)
);
